@@ rtl/dlestx_pkg.sv @@
// ----------------------------------------------------------------------------
// dlestx_pkg
// Shared types, byte codes and CRC-16 helpers for the DLE/STX frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dlestx_pkg;

	localparam int HEADER_BYTES_DEF  = 4;
	localparam int PAYLOAD_BYTES_DEF = 252;

	localparam logic [7:0]  BYTE_SYN = 8'h16;
	localparam logic [7:0]  BYTE_DLE = 8'h10;
	localparam logic [7:0]  BYTE_STX = 8'h02;
	localparam logic [7:0]  BYTE_ETX = 8'h03;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_SYN  = 3'd0,
		PH_DLE  = 3'd1,
		PH_STX  = 3'd2,
		PH_BODY = 3'd3,
		PH_ESC  = 3'd4,
		PH_FCS1 = 3'd5,
		PH_FCS2 = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_BODY     = 3'd1,
		EV_GOOD     = 3'd2,
		EV_CRC_ERR  = 3'd3,
		EV_BAD_ESC  = 3'd4,
		EV_OVERFLOW = 3'd5
	} event_t;

	typedef struct packed {
		event_t     kind;
		logic [7:0] body_byte;
		logic [7:0] body_index;
		logic [7:0] frame_length;
	} result_t;

	// Table entry for one index: XOR of eight basis words derived from the
	// reflected polynomial, each stored byte-swapped.
	function automatic logic [15:0] crc_table(input logic [7:0] idx);
		logic [15:0] sh;
		logic        carry;
		logic [15:0] q;
		sh    = '0;
		carry = 1'b1;
		q     = '0;
		for (int i = 0; i < 8; i++) begin
			if (carry) begin
				sh = sh ^ CRC_POLY;
			end
			if (idx[7-i]) begin
				q = q ^ {sh[7:0], sh[15:8]};
			end
			carry = sh[0];
			sh    = sh >> 1;
		end
		return q;
	endfunction

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] q;
		q = crc_table(b ^ crc[15:8]);
		return {q[15:8] ^ crc[7:0], q[7:0]};
	endfunction

endpackage

`default_nettype wire

@@ rtl/dlestx_core.sv @@
// ----------------------------------------------------------------------------
// dlestx_core
// Frame state machine, body counter, running CRC and the result of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dlestx_core import dlestx_pkg::*; #(
	parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx,
	output result_t         res
);

	localparam int CAPACITY = HEADER_BYTES + PAYLOAD_BYTES;
	localparam int CNT_W    = $clog2(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CAPACITY - 1);

	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [15:0]       crc_q, crc_d;
	logic [7:0]        fcs_hi_q, fcs_hi_d;
	logic [15:0]       crc_body;

	assign crc_body = crc_update(crc_q, rx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYN;
			count_q  <= '0;
			crc_q    <= CRC_INIT;
			fcs_hi_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			crc_q    <= crc_d;
			fcs_hi_q <= fcs_hi_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		crc_d    = crc_q;
		fcs_hi_d = fcs_hi_q;
		res      = '{kind: EV_NONE, body_byte: '0, body_index: '0, frame_length: '0};
		unique case (phase_q)
			PH_DLE: begin
				phase_d = (rx == BYTE_DLE) ? PH_STX : PH_SYN;
			end
			PH_STX: begin
				phase_d = (rx == BYTE_STX) ? PH_BODY : PH_SYN;
			end
			PH_BODY: begin
				// A DLE still waiting for its partner counts toward capacity too.
				if (count_q >= CNT_LIMIT) begin
					res.kind = EV_OVERFLOW;
					phase_d  = PH_SYN;
				end else begin
					crc_d = crc_body;
					if (rx == BYTE_DLE) begin
						phase_d = PH_ESC;
					end else begin
						res.kind       = EV_BODY;
						res.body_byte  = rx;
						res.body_index = 8'(count_q);
						count_d        = count_q + 1'b1;
					end
				end
			end
			PH_ESC: begin
				if (rx == BYTE_DLE) begin
					res.kind       = EV_BODY;
					res.body_byte  = BYTE_DLE;
					res.body_index = 8'(count_q);
					count_d        = count_q + 1'b1;
					phase_d        = PH_BODY;
				end else if (rx == BYTE_ETX) begin
					crc_d   = crc_body;
					phase_d = PH_FCS1;
				end else begin
					res.kind = EV_BAD_ESC;
					phase_d  = PH_SYN;
				end
			end
			PH_FCS1: begin
				fcs_hi_d = rx;
				phase_d  = PH_FCS2;
			end
			PH_FCS2: begin
				res.kind         = ((~crc_q) == {fcs_hi_q, rx}) ? EV_GOOD : EV_CRC_ERR;
				res.frame_length = 8'(count_q);
				phase_d          = PH_SYN;
			end
			default: begin
				if (rx == BYTE_SYN) begin
					count_d = '0;
					crc_d   = CRC_INIT;
					phase_d = PH_DLE;
				end else begin
					phase_d = PH_SYN;
				end
			end
		endcase
	end

	// The stored body count never passes the overflow limit.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_LIMIT)
		else $error("body count beyond capacity");

	// A SYN while hunting starts a fresh frame.
	a_syn_start: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_SYN && rx == BYTE_SYN |=>
		crc_q == CRC_INIT && count_q == '0 && phase_q == PH_DLE)
		else $error("frame start did not preset state");

	// Each reported body byte advances the count by exactly one.
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.kind == EV_BODY |=> count_q == $past(count_q) + 1'b1)
		else $error("body count did not follow body byte");

	// A frame verdict only comes from the second FCS byte.
	a_verdict_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(res.kind == EV_GOOD || res.kind == EV_CRC_ERR) |-> phase_q == PH_FCS2)
		else $error("frame verdict outside FCS phase");

endmodule

`default_nettype wire

@@ rtl/dle_stx_frame_receiver_crc16_unit.sv @@
// ----------------------------------------------------------------------------
// dle_stx_frame_receiver_crc16_unit
// Byte-stuffed DLE/STX/ETX frame receiver with CRC-16 frame check.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  -------  ---------  --------------------  ----------------------------------
//  in       sink       in_valid / in_ready   rx_byte
//  out      source     out_valid / out_ready event_kind, body_byte, body_index,
//                                            frame_length
//
// Every request yields exactly one result: the byte is held in the input
// register, then its result goes to the result register. One request per
// cycle is sustained while out_ready is high; the table CRC update and the phase
// change are done in the single stage between the input and result registers.
// A stalled result holds the result register and, behind it, the input
// register; in_ready drops only when both are full and out_ready is low.
// Reset clears the frame state to hunting for SYN and empties both registers.
//
`default_nettype none

module dle_stx_frame_receiver_crc16_unit import dlestx_pkg::*; #(
	parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      event_kind,
	output logic [7:0]      body_byte,
	output logic [7:0]      body_index,
	output logic [7:0]      frame_length
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res;
	logic       advance;
	logic       step;

	assign advance  = !valid_s2 || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	dlestx_core #(
		.HEADER_BYTES  (HEADER_BYTES),
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.rx     (byte_s1),
		.res    (res)
	);

	assign out_valid    = valid_s2;
	assign event_kind   = res_s2.kind;
	assign body_byte    = res_s2.body_byte;
	assign body_index   = res_s2.body_index;
	assign frame_length = res_s2.frame_length;

endmodule

`default_nettype wire
